### rtl/venkat_slope_limiter_top_defines.svh
// Assertion macros used by the slope limiter controller.
// Expects signals named clk and rst_n in the scope of use.
`ifndef VENKAT_SLOPE_LIMITER_TOP_DEFINES_SVH
`define VENKAT_SLOPE_LIMITER_TOP_DEFINES_SVH

// Check that the consequent holds in the same cycle as the antecedent
`define VSL_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that the consequent holds in the cycle after the antecedent
`define VSL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/vsl_pkg.sv
// Shared types and constants of the slope limiter.
// No dependencies; imported by the controller, datapath and top level.
package vsl_pkg;

    localparam int DEF_MAX_FACES     = 8;
    localparam int DEF_DIMENSIONS    = 3;
    localparam int DEF_FRACTION_BITS = 16;

    localparam int WORD_W     = 32;
    localparam int IN_DATA_W  = 9 * WORD_W;
    localparam int OUT_DATA_W = 24;
    localparam int LIMITER_W  = 18;

    typedef enum logic [4:0] {
        S_IDLE,
        S_K2,
        S_K3,
        S_EPS,
        S_DLIM,
        S_FETCH,
        S_DX,
        S_DY,
        S_DZ,
        S_DSUM,
        S_BB,
        S_BD,
        S_DD,
        S_SUM,
        S_DIV,
        S_CMP,
        S_DONE
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_K2,
        OP_K3,
        OP_EPS,
        OP_DLIM,
        OP_DX,
        OP_DY,
        OP_DZ,
        OP_DSUM,
        OP_BB,
        OP_BD,
        OP_DD,
        OP_SUM,
        OP_DIV,
        OP_CMP
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   capture;
        logic   finish;
    } cmd_t;

    typedef struct packed {
        logic delta_zero;
        logic den_zero;
        logic more_faces;
        logic out_busy;
    } stat_t;

endpackage

### rtl/vsl_dp.sv
// Datapath of the slope limiter: face store, min/max, shared multiplier,
// restoring divider and result register. Depends on vsl_pkg.
module vsl_dp
    import vsl_pkg::*;
#(
    parameter int MAX_FACES     = DEF_MAX_FACES,
    parameter int FRACTION_BITS = DEF_FRACTION_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    input  logic [WORD_W-1:0]     cfg_data,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  cmd_t                  cmd,
    output stat_t                 stat,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic [0:0]            m_tuser
);

    localparam int IW    = $clog2(MAX_FACES);
    localparam int CW    = $clog2(MAX_FACES + 1);
    localparam int PRODW = 66;
    localparam int SHW   = PRODW - FRACTION_BITS;
    localparam int MAGW  = 63 - FRACTION_BITS;
    localparam int NUMW  = 65 - FRACTION_BITS;
    localparam int QB    = FRACTION_BITS + 2;
    localparam int ACCW  = SHW + 2;
    localparam logic [QB-1:0] ONE = QB'(1) << FRACTION_BITS;
    localparam logic [QB-1:0] TWO = QB'(2) << FRACTION_BITS;

    // Input fields
    logic signed [WORD_W-1:0] in_cell, in_gx, in_gy, in_gz, in_nb, in_rx, in_ry, in_rz;
    logic        [WORD_W-1:0] in_vol;

    assign in_cell = s_tdata[31:0];
    assign in_vol  = s_tdata[63:32];
    assign in_gx   = s_tdata[95:64];
    assign in_gy   = s_tdata[127:96];
    assign in_gz   = s_tdata[159:128];
    assign in_nb   = s_tdata[191:160];
    assign in_rx   = s_tdata[223:192];
    assign in_ry   = s_tdata[255:224];
    assign in_rz   = s_tdata[287:256];

    // Registers
    logic        [WORD_W-1:0] k_reg;
    logic signed [WORD_W-1:0] cell_reg, gx_reg, gy_reg, gz_reg, max_reg, min_reg;
    logic        [WORD_W-1:0] vol_reg;
    logic        [CW-1:0]     count_reg;
    logic        [IW-1:0]     idx_reg;
    logic                     ovf_reg;
    logic signed [PRODW-1:0]  prod_reg;
    logic        [WORD_W-1:0] eps_reg;
    logic signed [WORD_W-1:0] dmax_reg, dmin_reg, delta_reg;
    logic signed [ACCW-1:0]   acc_reg;
    logic        [WORD_W-1:0] dmag_reg;
    logic        [MAGW-1:0]   b2_reg, bd_reg;
    logic        [NUMW-1:0]   den_reg, rem_reg;
    logic        [QB-1:0]     sh_reg, q_reg, best_reg;
    logic signed [WORD_W-1:0] rx_rd_reg, ry_rd_reg, rz_rd_reg;
    logic                     m_tvalid_reg;
    logic [OUT_DATA_W-1:0]    m_tdata_reg;
    logic                     m_tuser_reg;

    logic signed [WORD_W-1:0] rx_mem [MAX_FACES];
    logic signed [WORD_W-1:0] ry_mem [MAX_FACES];
    logic signed [WORD_W-1:0] rz_mem [MAX_FACES];

    // Combinational helpers
    logic                     first_face, store_full;
    logic signed [WORD_W-1:0] max_base, min_base;
    logic signed [32:0]       mul_a, mul_b;
    logic signed [SHW-1:0]    prod_sh;
    logic                     usat_ovf;
    logic        [WORD_W-1:0] usat_val;
    logic signed [32:0]       dmax_diff, dmin_diff;
    logic                     dmax_ovf, dmin_ovf;
    logic signed [WORD_W-1:0] dmax_sat, dmin_sat;
    logic signed [ACCW-1:0]   dsum;
    logic                     dsum_ovf;
    logic signed [WORD_W-1:0] dsum_sat;
    logic        [WORD_W-1:0] bmag, dsel_mag;
    logic signed [WORD_W-1:0] dsel;
    logic        [NUMW-1:0]   num, den;
    logic        [NUMW:0]     trial;
    logic                     trial_ge;
    logic        [QB-1:0]     phi;

    assign first_face = (count_reg == '0);
    assign store_full = (count_reg >= CW'(MAX_FACES));
    assign max_base   = first_face ? in_cell : max_reg;
    assign min_base   = first_face ? in_cell : min_reg;

    // Select multiplier operands for the current step
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_K2:
            begin
                mul_a = {1'b0, k_reg};
                mul_b = {1'b0, k_reg};
            end
            OP_K3:
            begin
                mul_a = {1'b0, usat_val};
                mul_b = {1'b0, k_reg};
            end
            OP_EPS:
            begin
                mul_a = {1'b0, usat_val};
                mul_b = {1'b0, vol_reg};
            end
            OP_DX:
            begin
                mul_a = {gx_reg[31], gx_reg};
                mul_b = {rx_rd_reg[31], rx_rd_reg};
            end
            OP_DY:
            begin
                mul_a = {gy_reg[31], gy_reg};
                mul_b = {ry_rd_reg[31], ry_rd_reg};
            end
            OP_DZ:
            begin
                mul_a = {gz_reg[31], gz_reg};
                mul_b = {rz_rd_reg[31], rz_rd_reg};
            end
            OP_BB:
            begin
                mul_a = {1'b0, bmag};
                mul_b = {1'b0, bmag};
            end
            OP_BD:
            begin
                mul_a = {1'b0, bmag};
                mul_b = {1'b0, dmag_reg};
            end
            OP_DD:
            begin
                mul_a = {1'b0, dmag_reg};
                mul_b = {1'b0, dmag_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Scale the product back to Q format, rounding toward minus infinity
    assign prod_sh  = SHW'(prod_reg >>> FRACTION_BITS);
    assign usat_ovf = |prod_sh[SHW-1:WORD_W];
    assign usat_val = usat_ovf ? '1 : prod_sh[WORD_W-1:0];

    // Saturated neighbor differences
    assign dmax_diff = {max_reg[31], max_reg} - {cell_reg[31], cell_reg};
    assign dmin_diff = {min_reg[31], min_reg} - {cell_reg[31], cell_reg};
    assign dmax_ovf  = dmax_diff[32] != dmax_diff[31];
    assign dmin_ovf  = dmin_diff[32] != dmin_diff[31];
    assign dmax_sat  = dmax_ovf ? (dmax_diff[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF)
                                : dmax_diff[31:0];
    assign dmin_sat  = dmin_ovf ? (dmin_diff[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF)
                                : dmin_diff[31:0];

    // Saturated delta2
    assign dsum     = acc_reg + ACCW'(prod_sh);
    assign dsum_ovf = !((&dsum[ACCW-1:31]) || !(|dsum[ACCW-1:31]));
    assign dsum_sat = dsum_ovf ? (dsum[ACCW-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF)
                               : dsum[31:0];

    // Magnitudes of delta2 and of the chosen difference
    assign bmag     = delta_reg[31] ? 32'(~delta_reg + 32'sd1) : delta_reg;
    assign dsel     = delta_reg[31] ? dmin_reg : dmax_reg;
    assign dsel_mag = dsel[31] ? 32'(~dsel + 32'sd1) : dsel;

    // Numerator, denominator and one divider step
    assign num = NUMW'(prod_sh[MAGW-1:0]) + NUMW'(eps_reg) + (NUMW'(bd_reg) << 1);
    assign den = NUMW'(prod_sh[MAGW-1:0]) + (NUMW'(b2_reg) << 1) + NUMW'(bd_reg)
               + NUMW'(eps_reg);
    assign trial    = {rem_reg, sh_reg[QB-1]};
    assign trial_ge = trial >= {1'b0, den_reg};
    assign phi      = (stat.delta_zero || stat.den_zero) ? ONE : q_reg;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg <= WORD_W'(1) << FRACTION_BITS;
        end
        else if (cfg_valid)
        begin
            k_reg <= cfg_data;
        end
    end

    // Run control: face count, min/max, sticky overflow
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            max_reg   <= '0;
            min_reg   <= '0;
            cell_reg  <= '0;
            vol_reg   <= '0;
            gx_reg    <= '0;
            gy_reg    <= '0;
            gz_reg    <= '0;
            ovf_reg   <= 1'b0;
        end
        else if (cmd.capture)
        begin
            if (first_face)
            begin
                cell_reg <= in_cell;
                vol_reg  <= in_vol;
                gx_reg   <= in_gx;
                gy_reg   <= in_gy;
                gz_reg   <= in_gz;
            end
            max_reg <= (in_nb > max_base) ? in_nb : max_base;
            min_reg <= (in_nb < min_base) ? in_nb : min_base;
            ovf_reg <= (first_face ? 1'b0 : ovf_reg) | store_full;
            if (!store_full)
            begin
                count_reg <= count_reg + CW'(1);
            end
        end
        else if (cmd.finish)
        begin
            count_reg <= '0;
        end
        else
        begin
            case (cmd.op)
                OP_K3, OP_EPS:
                begin
                    ovf_reg <= ovf_reg | usat_ovf;
                end
                OP_DLIM:
                begin
                    ovf_reg <= ovf_reg | usat_ovf | dmax_ovf | dmin_ovf;
                end
                OP_DSUM:
                begin
                    ovf_reg <= ovf_reg | dsum_ovf;
                end
                default:
                begin
                    ovf_reg <= ovf_reg;
                end
            endcase
        end
    end

    // Face vector store: write on request, registered read at the face index
    always_ff @(posedge clk)
    begin
        if (cmd.capture && !store_full)
        begin
            rx_mem[count_reg[IW-1:0]] <= in_rx;
            ry_mem[count_reg[IW-1:0]] <= in_ry;
            rz_mem[count_reg[IW-1:0]] <= in_rz;
        end
        rx_rd_reg <= rx_mem[idx_reg];
        ry_rd_reg <= ry_mem[idx_reg];
        rz_rd_reg <= rz_mem[idx_reg];
    end

    // Face index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else if (cmd.op == OP_DLIM)
        begin
            idx_reg <= '0;
        end
        else if (cmd.op == OP_CMP)
        begin
            idx_reg <= idx_reg + IW'(1);
        end
    end

    // Arithmetic pipeline registers
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        case (cmd.op)
            OP_DLIM:
            begin
                eps_reg  <= usat_val;
                dmax_reg <= dmax_sat;
                dmin_reg <= dmin_sat;
                best_reg <= TWO;
            end
            OP_DY:
            begin
                acc_reg <= ACCW'(prod_sh);
            end
            OP_DZ:
            begin
                acc_reg <= dsum;
            end
            OP_DSUM:
            begin
                delta_reg <= dsum_sat;
            end
            OP_BB:
            begin
                dmag_reg <= dsel_mag;
            end
            OP_BD:
            begin
                b2_reg <= prod_sh[MAGW-1:0];
            end
            OP_DD:
            begin
                bd_reg <= prod_sh[MAGW-1:0];
            end
            OP_SUM:
            begin
                den_reg <= den;
                rem_reg <= num >> 2;
                sh_reg  <= {num[1:0], {FRACTION_BITS{1'b0}}};
                q_reg   <= '0;
            end
            OP_DIV:
            begin
                rem_reg <= trial_ge ? NUMW'(trial - {1'b0, den_reg}) : trial[NUMW-1:0];
                q_reg   <= {q_reg[QB-2:0], trial_ge};
                sh_reg  <= sh_reg << 1;
            end
            OP_CMP:
            begin
                best_reg <= (phi < best_reg) ? phi : best_reg;
            end
            default:
            begin
                acc_reg <= acc_reg;
            end
        endcase
    end

    // Output register: load on finish, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            m_tdata_reg <= OUT_DATA_W'(LIMITER_W'(best_reg));
            m_tuser_reg <= ovf_reg;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser    = m_tuser_reg;

    assign stat.delta_zero = (delta_reg == '0);
    assign stat.den_zero   = (den_reg == '0);
    assign stat.more_faces = (CW'(idx_reg) + CW'(1)) < count_reg;
    assign stat.out_busy   = m_tvalid_reg && !m_tready;

endmodule

### rtl/vsl_ctrl.sv
// Sequencer of the slope limiter: steps the datapath through epsilon,
// the per-face ratio and the divider. Depends on vsl_pkg and the defines header.
`include "venkat_slope_limiter_top_defines.svh"

module vsl_ctrl
    import vsl_pkg::*;
#(
    parameter int DIMENSIONS    = DEF_DIMENSIONS,
    parameter int FRACTION_BITS = DEF_FRACTION_BITS
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  s_tvalid,
    input  logic  s_tlast,
    output logic  s_tready,
    input  stat_t stat,
    output cmd_t  cmd
);

    localparam int QB  = FRACTION_BITS + 2;
    localparam int DCW = $clog2(QB + 1);

    state_t         state_reg, state_next;
    logic [DCW-1:0] div_cnt_reg, div_cnt_next;
    logic           div_last;

    assign div_last = (div_cnt_reg == DCW'(QB - 1));

    // Next state
    always_comb
    begin
        state_next   = state_reg;
        div_cnt_next = div_cnt_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid && s_tlast)
                begin
                    state_next = S_K2;
                end
            end
            S_K2:    state_next = S_K3;
            S_K3:    state_next = S_EPS;
            S_EPS:   state_next = S_DLIM;
            S_DLIM:  state_next = S_FETCH;
            S_FETCH: state_next = S_DX;
            S_DX:    state_next = S_DY;
            S_DY:    state_next = (DIMENSIONS > 2) ? S_DZ : S_DSUM;
            S_DZ:    state_next = S_DSUM;
            S_DSUM:  state_next = S_BB;
            S_BB:    state_next = stat.delta_zero ? S_CMP : S_BD;
            S_BD:    state_next = S_DD;
            S_DD:    state_next = S_SUM;
            S_SUM:
            begin
                state_next   = S_DIV;
                div_cnt_next = '0;
            end
            S_DIV:
            begin
                if (stat.den_zero || div_last)
                begin
                    state_next = S_CMP;
                end
                div_cnt_next = div_cnt_reg + DCW'(1);
            end
            S_CMP:   state_next = stat.more_faces ? S_FETCH : S_DONE;
            S_DONE:
            begin
                if (!stat.out_busy)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd.op      = OP_NONE;
        cmd.capture = 1'b0;
        cmd.finish  = 1'b0;
        s_tready    = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            S_K2:    cmd.op = OP_K2;
            S_K3:    cmd.op = OP_K3;
            S_EPS:   cmd.op = OP_EPS;
            S_DLIM:  cmd.op = OP_DLIM;
            S_DX:    cmd.op = OP_DX;
            S_DY:    cmd.op = OP_DY;
            S_DZ:    cmd.op = OP_DZ;
            S_DSUM:  cmd.op = OP_DSUM;
            S_BB:    cmd.op = OP_BB;
            S_BD:    cmd.op = OP_BD;
            S_DD:    cmd.op = OP_DD;
            S_SUM:   cmd.op = OP_SUM;
            S_DIV:   cmd.op = OP_DIV;
            S_CMP:   cmd.op = OP_CMP;
            S_DONE:  cmd.finish = !stat.out_busy;
            default: cmd.op = OP_NONE;
        endcase
    end

    // State and divider step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            div_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            div_cnt_reg <= div_cnt_next;
        end
    end

    `VSL_ASSERT_NEXT(a_div_ends, (state_reg == S_DIV) && !stat.den_zero && div_last, (state_reg == S_CMP), "divider ran past its step count")
    `VSL_ASSERT_SAME(a_start_from_idle, (state_reg == S_K2), ($past(state_reg) == S_IDLE), "epsilon sequence entered outside a last-face request")
    `VSL_ASSERT_NEXT(a_done_releases, (state_reg == S_DONE) && !stat.out_busy, (state_reg == S_IDLE), "finished cell did not return to idle")

endmodule

### rtl/venkat_slope_limiter_top.sv
// Venkatakrishnan slope limiter, one variable of one cell, Q-format fixed point.
// Top level: joins vsl_ctrl and vsl_dp; depends on vsl_pkg.
//
// Face requests of a cell are taken one per cycle; the request with tlast
// set closes the cell. The block then steps through K2, K3, EPS and DLIM to
// form epsilon and the neighbor differences, and per stored face through
// FETCH, DX, DY, DZ, DSUM, BB, BD, DD, SUM, DIV and CMP (one shared 33x33
// multiplier for the dot product and the d/b products, then a restoring
// divider giving one quotient bit per cycle, then the compare); DZ is
// skipped with two dimensions, and a face with zero delta2 skips BD, DD,
// SUM and DIV. DONE then loads the result. New face requests are held
// off from the last face until the result is in the output register, which
// also waits for the previous result to be taken. The result carries the
// minimum ratio in tdata and the run's saturation flag in tuser.
module venkat_slope_limiter_top
    import vsl_pkg::*;
#(
    parameter int MAX_FACES     = DEF_MAX_FACES,
    parameter int DIMENSIONS    = DEF_DIMENSIONS,
    parameter int FRACTION_BITS = DEF_FRACTION_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [WORD_W-1:0]     cfg_data,     // smoothness_k
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // cell_value, cell_volume, grad_x, grad_y, grad_z, neighbor_value, r_x, r_y, r_z
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  s_tlast,      // last_face
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,      // limiter, zero fill
    output logic [0:0]            m_tuser       // overflow
);

    cmd_t  cmd;
    stat_t stat;

    assign cfg_ready = 1'b1;

    vsl_ctrl #(
        .DIMENSIONS    (DIMENSIONS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    vsl_dp #(
        .MAX_FACES     (MAX_FACES),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .stat      (stat),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule
